[rtl/core/cdf_pkg.sv]
package cdf_pkg;

    localparam int TAP_IDX_W = 6;
    localparam int TAP_VAL_W = 16;
    localparam int SUM_W     = 38;
    localparam int OUT_IDX_W = 16;
    localparam int CNT_W     = 16;
    localparam int TAPCNT_W  = 7;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int OUT_TD_W  = ((2 * SUM_W + OUT_IDX_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_LOAD_TAP = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd1;
    localparam logic [OP_W-1:0] OP_START    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_DONE
    } cdf_state_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } cdf_line_ctl_t;

    typedef struct packed {
        logic clear;
        logic take;
    } cdf_mac_ctl_t;

endpackage

[rtl/core/cdf_cell.sv]
module cdf_cell
    import cdf_pkg::*;
#(
    parameter int DATA_W = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cdf_line_ctl_t            ctl,
    input  logic signed [DATA_W-1:0] shift_in_re,
    input  logic signed [DATA_W-1:0] shift_in_im,
    input  logic signed [DATA_W-1:0] rot_in_re,
    input  logic signed [DATA_W-1:0] rot_in_im,
    output logic signed [DATA_W-1:0] q_re,
    output logic signed [DATA_W-1:0] q_im
);

    logic signed [DATA_W-1:0] re_reg;
    logic signed [DATA_W-1:0] im_reg;
    logic signed [DATA_W-1:0] re_next;
    logic signed [DATA_W-1:0] im_next;

    always_comb
    begin
        re_next = re_reg;
        im_next = im_reg;
        if (ctl.shift)
        begin
            re_next = shift_in_re;
            im_next = shift_in_im;
        end
        else if (ctl.rotate)
        begin
            re_next = rot_in_re;
            im_next = rot_in_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_reg <= '0;
            im_reg <= '0;
        end
        else
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    assign q_re = re_reg;
    assign q_im = im_reg;

endmodule

[rtl/core/cdf_chain.sv]
module cdf_chain
    import cdf_pkg::*;
#(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdf_line_ctl_t                 ctl,
    input  logic signed [SAMPLE_BITS-1:0] new_re,
    input  logic signed [SAMPLE_BITS-1:0] new_im,
    output logic signed [SAMPLE_BITS-1:0] head_re,
    output logic signed [SAMPLE_BITS-1:0] head_im
);

    logic signed [SAMPLE_BITS-1:0] q_re [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] q_im [MAX_TAPS];

    // shift moves data toward the tail, rotate moves it toward the head
    for (genvar i = 0; i < MAX_TAPS; i++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] sh_re;
        logic signed [SAMPLE_BITS-1:0] sh_im;
        logic signed [SAMPLE_BITS-1:0] ro_re;
        logic signed [SAMPLE_BITS-1:0] ro_im;

        if (i == 0)
        begin : g_first
            assign sh_re = new_re;
            assign sh_im = new_im;
        end
        else
        begin : g_mid
            assign sh_re = q_re[i-1];
            assign sh_im = q_im[i-1];
        end

        if (i == MAX_TAPS - 1)
        begin : g_last
            assign ro_re = q_re[0];
            assign ro_im = q_im[0];
        end
        else
        begin : g_inner
            assign ro_re = q_re[i+1];
            assign ro_im = q_im[i+1];
        end

        cdf_cell #(
            .DATA_W (SAMPLE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .shift_in_re (sh_re),
            .shift_in_im (sh_im),
            .rot_in_re   (ro_re),
            .rot_in_im   (ro_im),
            .q_re        (q_re[i]),
            .q_im        (q_im[i])
        );
    end

    assign head_re = q_re[0];
    assign head_im = q_im[0];

endmodule

[rtl/core/cdf_mac.sv]
module cdf_mac
    import cdf_pkg::*;
#(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tap_we,
    input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] tap_wr_addr,
    input  logic signed [TAP_VAL_W-1:0]   tap_wr_value,
    input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] tap_rd_addr,
    input  cdf_mac_ctl_t                  ctl,
    input  logic signed [SAMPLE_BITS-1:0] head_re,
    input  logic signed [SAMPLE_BITS-1:0] head_im,
    output logic signed [SUM_W-1:0]       sum_re,
    output logic signed [SUM_W-1:0]       sum_im
);

    localparam int PROD_W = SAMPLE_BITS + TAP_VAL_W;
    localparam int GROW_W = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int ACC_W  = (GROW_W > SUM_W + 1) ? GROW_W : SUM_W + 1;

    logic signed [TAP_VAL_W-1:0]   tap_mem [MAX_TAPS];
    logic signed [TAP_VAL_W-1:0]   tap_q_reg;
    logic signed [SAMPLE_BITS-1:0] d_re_reg;
    logic signed [SAMPLE_BITS-1:0] d_im_reg;
    logic                          v1_reg;
    logic signed [PROD_W-1:0]      p_re_reg;
    logic signed [PROD_W-1:0]      p_im_reg;
    logic                          v2_reg;
    logic signed [ACC_W-1:0]       acc_re_reg;
    logic signed [ACC_W-1:0]       acc_im_reg;
    logic signed [ACC_W-1:0]       acc_re_next;
    logic signed [ACC_W-1:0]       acc_im_next;

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[tap_wr_addr] <= tap_wr_value;
        end
        tap_q_reg <= tap_mem[tap_rd_addr];
        d_re_reg  <= head_re;
        d_im_reg  <= head_im;
        p_re_reg  <= d_re_reg * tap_q_reg;
        p_im_reg  <= d_im_reg * tap_q_reg;
    end

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctl.clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (v2_reg)
        begin
            acc_re_next = acc_re_reg + ACC_W'(p_re_reg);
            acc_im_next = acc_im_reg + ACC_W'(p_im_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            v1_reg     <= ctl.take;
            v2_reg     <= v1_reg;
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    // saturate to the output range
    always_comb
    begin
        if ((&acc_re_reg[ACC_W-1:SUM_W-1]) || !(|acc_re_reg[ACC_W-1:SUM_W-1]))
        begin
            sum_re = acc_re_reg[SUM_W-1:0];
        end
        else
        begin
            sum_re = acc_re_reg[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
        end
        if ((&acc_im_reg[ACC_W-1:SUM_W-1]) || !(|acc_im_reg[ACC_W-1:SUM_W-1]))
        begin
            sum_im = acc_im_reg[SUM_W-1:0];
        end
        else
        begin
            sum_im = acc_im_reg[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

endmodule

[rtl/core/complex_decimating_fir_top.sv]
// channel  | direction | payload
// s_axis   | in        | tuser: operation; tdata: tap_index, tap_value, sample_re, sample_im
// m_axis   | out       | tdata: out_re, out_im, out_index; tlast: out_last
// cfg      | in        | cfg_we, cfg_index, cfg_data (tap_count, decim, output_count)
//
// tap loads, frame starts, ignored and non-firing samples leave the block in ST_IDLE
// a sample that completes a window keeps s_tready low while the delay line is
// rotated once around through the single multiply-accumulate unit at the head
// the result sits in an output register, so the next item is taken while it waits
// reset clears the delay line, counters and accumulators; taps are undefined until loaded
module complex_decimating_fir_top
    import cdf_pkg::*;
#(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    // tap_index, tap_value, sample_re, sample_im, zero fill
    input  logic [((TAP_IDX_W + TAP_VAL_W + 2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // operation
    input  logic [OP_W-1:0]                                  s_tuser,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    // out_re, out_im, out_index, zero fill
    output logic [OUT_TD_W-1:0]                              m_tdata,
    output logic                                             m_tlast,
    input  logic                                             cfg_we,
    input  logic [CFG_IDX_W-1:0]                             cfg_index,
    input  logic [CFG_W-1:0]                                 cfg_data
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int RE_LO = TAP_IDX_W + TAP_VAL_W;
    localparam int IM_LO = RE_LO + SAMPLE_BITS;

    logic [TAP_IDX_W-1:0]          tap_index;
    logic signed [TAP_VAL_W-1:0]   tap_value;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;

    cdf_state_t         state_reg;
    cdf_state_t         state_next;
    logic [AW-1:0]      r_reg;
    logic [TW-1:0]      fill_reg;
    logic [CNT_W-1:0]   phase_reg;
    logic [CNT_W-1:0]   emitted_reg;
    logic [TAPCNT_W-1:0] tap_count_reg;
    logic [CNT_W-1:0]   decim_reg;
    logic [CNT_W-1:0]   output_count_reg;
    logic [OUT_IDX_W-1:0] idx_hold_reg;
    logic               last_hold_reg;
    logic               m_tvalid_reg;
    logic signed [SUM_W-1:0] out_re_reg;
    logic signed [SUM_W-1:0] out_im_reg;
    logic [OUT_IDX_W-1:0] out_index_reg;
    logic               out_last_reg;

    logic               accept;
    logic               is_sample;
    logic               fire;
    logic               out_free;
    logic               out_load;
    logic               in_window;
    logic [TW-1:0]      t_eff;
    logic [TW-1:0]      fill_next;
    logic [CNT_W-1:0]   phase_next;
    logic [CNT_W-1:0]   step;
    logic               tap_we;
    logic [AW-1:0]      tap_rd_addr;
    cdf_line_ctl_t      line_ctl;
    cdf_mac_ctl_t       mac_ctl;
    logic signed [SAMPLE_BITS-1:0] head_re;
    logic signed [SAMPLE_BITS-1:0] head_im;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;

    assign tap_index = s_tdata[TAP_IDX_W-1:0];
    assign tap_value = s_tdata[TAP_IDX_W +: TAP_VAL_W];
    assign sample_re = s_tdata[RE_LO +: SAMPLE_BITS];
    assign sample_im = s_tdata[IM_LO +: SAMPLE_BITS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_sample = accept && (s_tuser == OP_SAMPLE) && (emitted_reg < output_count_reg);
    assign tap_we    = accept && (s_tuser == OP_LOAD_TAP) && (int'(tap_index) < MAX_TAPS);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign t_eff      = (int'(tap_count_reg) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(tap_count_reg);
    assign fill_next  = (fill_reg == TW'(MAX_TAPS)) ? fill_reg : fill_reg + TW'(1);
    assign phase_next = (&phase_reg) ? phase_reg : phase_reg + CNT_W'(1);
    assign step       = (decim_reg == '0) ? CNT_W'(1) : decim_reg;
    assign fire       = (emitted_reg == '0) ? (fill_next >= t_eff) : (phase_next >= step);

    assign in_window   = TW'(r_reg) < t_eff;
    assign tap_rd_addr = AW'(t_eff - TW'(1) - TW'(r_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_sample && fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (r_reg == AW'(MAX_TAPS - 1))
                begin
                    state_next = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A: state_next = ST_DRAIN_B;
            ST_DRAIN_B: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        line_ctl.shift  = 1'b0;
        line_ctl.rotate = 1'b0;
        mac_ctl.clear   = 1'b0;
        mac_ctl.take    = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                line_ctl.shift = is_sample;
                mac_ctl.clear  = is_sample && fire;
            end
            ST_RUN:
            begin
                line_ctl.rotate = 1'b1;
                mac_ctl.take    = in_window;
            end
            ST_DRAIN_A, ST_DRAIN_B:
            begin
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            r_reg            <= '0;
            fill_reg         <= '0;
            phase_reg        <= '0;
            emitted_reg      <= '0;
            tap_count_reg    <= TAPCNT_W'(1);
            decim_reg        <= CNT_W'(1);
            output_count_reg <= CNT_W'(1);
            idx_hold_reg     <= '0;
            last_hold_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_RUN)
            begin
                r_reg <= r_reg + AW'(1);
            end
            else
            begin
                r_reg <= '0;
            end

            if (accept && (s_tuser == OP_START))
            begin
                fill_reg    <= '0;
                phase_reg   <= '0;
                emitted_reg <= '0;
            end
            else if (is_sample)
            begin
                fill_reg <= fill_next;
                if (fire)
                begin
                    phase_reg     <= '0;
                    emitted_reg   <= emitted_reg + CNT_W'(1);
                    idx_hold_reg  <= emitted_reg;
                    last_hold_reg <= ((CNT_W + 1)'(emitted_reg) + (CNT_W + 1)'(1))
                                     == (CNT_W + 1)'(output_count_reg);
                end
                else
                begin
                    phase_reg <= phase_next;
                end
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TAP_COUNT:    tap_count_reg    <= cfg_data[TAPCNT_W-1:0];
                    CFG_DECIM:        decim_reg        <= cfg_data;
                    CFG_OUTPUT_COUNT: output_count_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_re_reg    <= sum_re;
            out_im_reg    <= sum_im;
            out_index_reg <= idx_hold_reg;
            out_last_reg  <= last_hold_reg;
        end
    end

    cdf_chain #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (line_ctl),
        .new_re  (sample_re),
        .new_im  (sample_im),
        .head_re (head_re),
        .head_im (head_im)
    );

    cdf_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .tap_we       (tap_we),
        .tap_wr_addr  (AW'(tap_index)),
        .tap_wr_value (tap_value),
        .tap_rd_addr  (tap_rd_addr),
        .ctl          (mac_ctl),
        .head_re      (head_re),
        .head_im      (head_im),
        .sum_re       (sum_re),
        .sum_im       (sum_im)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_TD_W - 2 * SUM_W - OUT_IDX_W){1'b0}},
                       out_index_reg, out_im_reg, out_re_reg};

endmodule
